@@ src/bcih_pkg.sv @@
`default_nettype none

package bcih_pkg;

  // sizes of the stores
  localparam int MAX_OVERLAPS = 1024;
  localparam int MAX_BINS     = 4096;
  localparam int MAX_DEPTH    = 1024;
  localparam int NUM_SETS     = 16;

  // field widths
  localparam int POS_W   = 20;
  localparam int BW_W    = 13;
  localparam int SET_W   = 4;
  localparam int DEPTH_W = 10;
  localparam int CNT_W   = 32;
  localparam int CMD_W   = 2;
  localparam int STS_W   = 2;
  localparam int CFG_AW  = 2;

  // derived widths
  localparam int OVL_AW  = $clog2(MAX_OVERLAPS);
  localparam int OVL_CW  = $clog2(MAX_OVERLAPS + 1);
  localparam int BIN_AW  = $clog2(MAX_BINS);
  localparam int BIN_CW  = $clog2(MAX_BINS + 1);
  localparam int DEP_AW  = $clog2(MAX_DEPTH);
  localparam int SETS_AW = $clog2(NUM_SETS);
  localparam int HIST_AW = SETS_AW + DEP_AW;
  localparam int KEY_W   = POS_W + 1;
  localparam int SPAN_W  = $clog2(2 * MAX_OVERLAPS + 1);
  localparam int STORE_W = 2 * POS_W;
  localparam int DIV_CW  = $clog2(POS_W);

  localparam logic [BW_W-1:0] BW_RESET = 13'd100;

  // configuration register indexes
  localparam logic [CFG_AW-1:0] CFG_MIN_OVL   = 2'd0;
  localparam logic [CFG_AW-1:0] CFG_MIN_READ  = 2'd1;
  localparam logic [CFG_AW-1:0] CFG_BIN_WIDTH = 2'd2;

  typedef enum logic [CMD_W-1:0] {
    CMD_ADD   = 2'd0,
    CMD_CLOSE = 2'd1,
    CMD_COUNT = 2'd2,
    CMD_MODE  = 2'd3
  } cmd_code_t;

  typedef enum logic [STS_W-1:0] {
    STS_OK   = 2'd0,
    STS_FULL = 2'd1,
    STS_CLIP = 2'd2
  } sts_code_t;

  // controller to datapath
  typedef struct packed {
    logic hclr_step;
    logic in_load;
    logic add_do;
    logic cclr_step;
    logic scan_init;
    logic scan_issue;
    logic cand_take;
    logic evt_setup;
    logic bin_wr;
    logic evt_end;
    logic hist_init;
    logic hist_rd_cnt;
    logic hist_wr;
    logic close_fin;
    logic qcnt_rd;
    logic qcnt_take;
    logic mode_init;
    logic mode_rd;
    logic mode_cmp;
    logic out_load;
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic hclr_last;
    logic cclr_last;
    logic sweep_empty;
    logic scan_last;
    logic cand_found;
    logic div_busy;
    logic bin_any;
    logic bin_last;
    logic evt_more;
    logic hist_last;
    logic mode_none;
    logic mode_last;
  } dp_sts_t;

endpackage

`default_nettype wire

@@ src/bcih_div.sv @@
`default_nettype none

module bcih_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       start,
  input  logic [bcih_pkg::POS_W-1:0] dividend,
  input  logic [bcih_pkg::BW_W-1:0]  divisor,
  output logic                       busy,
  output logic [bcih_pkg::POS_W-1:0] quo,
  output logic [bcih_pkg::BW_W-1:0]  rem
);
  import bcih_pkg::*;

  logic              busy_r;
  logic [DIV_CW-1:0] cnt_r;
  logic [POS_W-1:0]  quo_r, quo_nxt;
  logic [BW_W-1:0]   rem_r, rem_nxt, dvs_r;
  logic [BW_W:0]     trial;

  // one quotient bit a cycle, restoring
  always_comb begin
    trial = {rem_r, quo_r[POS_W-1]};
    if (trial >= {1'b0, dvs_r}) begin
      rem_nxt = BW_W'(trial - {1'b0, dvs_r});
      quo_nxt = {quo_r[POS_W-2:0], 1'b1};
    end else begin
      rem_nxt = trial[BW_W-1:0];
      quo_nxt = {quo_r[POS_W-2:0], 1'b0};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else if (start) begin
      busy_r <= 1'b1;
      cnt_r  <= '0;
      rem_r  <= '0;
      quo_r  <= dividend;
      dvs_r  <= (divisor == '0) ? BW_W'(1) : divisor;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      quo_r <= quo_nxt;
      cnt_r <= cnt_r + DIV_CW'(1);
      if (cnt_r == DIV_CW'(POS_W - 1)) begin
        busy_r <= 1'b0;
      end
    end
  end

  assign busy = busy_r;
  assign quo  = quo_r;
  assign rem  = rem_r;

endmodule

`default_nettype wire

@@ src/bcih_datapath.sv @@
`default_nettype none

module bcih_datapath (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [bcih_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [bcih_pkg::POS_W-1:0]   cfg_data,
  input  logic [bcih_pkg::POS_W-1:0]   in_begin_pos,
  input  logic [bcih_pkg::POS_W-1:0]   in_end_pos,
  input  logic                         in_self_match,
  input  logic [bcih_pkg::POS_W-1:0]   in_partner_len,
  input  logic [bcih_pkg::POS_W-1:0]   in_read_len,
  input  logic [bcih_pkg::SET_W-1:0]   in_set_id,
  input  logic [bcih_pkg::DEPTH_W-1:0] in_depth_bin,
  input  bcih_pkg::ctl_cmd_t           cmd,
  output bcih_pkg::dp_sts_t            sts,
  output logic [bcih_pkg::STS_W-1:0]   out_status,
  output logic [bcih_pkg::CNT_W-1:0]   out_bin_count,
  output logic [bcih_pkg::DEPTH_W-1:0] out_mode_depth,
  output logic [bcih_pkg::DEPTH_W-1:0] out_read_peak
);
  import bcih_pkg::*;

  // configuration registers
  logic [POS_W-1:0] min_ovl_r, min_read_r;
  logic [BW_W-1:0]  bw_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      min_ovl_r  <= '0;
      min_read_r <= '0;
      bw_r       <= BW_RESET;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        CFG_MIN_OVL:   min_ovl_r  <= cfg_data;
        CFG_MIN_READ:  min_read_r <= cfg_data;
        CFG_BIN_WIDTH: bw_r       <= cfg_data[BW_W-1:0];
        default: ;
      endcase
    end
  end

  // input beat latch
  logic [POS_W-1:0]   beg_r, end_r, plen_r, rlen_r;
  logic               self_r;
  logic [SET_W-1:0]   set_r;
  logic [DEPTH_W-1:0] dbin_r;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      beg_r  <= in_begin_pos;
      end_r  <= in_end_pos;
      self_r <= in_self_match;
      plen_r <= in_partner_len;
      rlen_r <= in_read_len;
      set_r  <= in_set_id;
      dbin_r <= in_depth_bin;
    end
  end

  // overlap filter
  logic [POS_W-1:0]  span_len;
  logic              add_drop, store_full, add_keep;
  logic [OVL_CW-1:0] ovl_cnt_r, n_eff;

  assign span_len   = end_r - beg_r;
  assign add_drop   = self_r || (end_r <= beg_r) || (span_len <= min_ovl_r) ||
                      (plen_r < min_read_r);
  assign store_full = ovl_cnt_r >= OVL_CW'(MAX_OVERLAPS);
  assign add_keep   = cmd.add_do && !add_drop && !store_full;
  assign n_eff      = (rlen_r >= min_read_r) ? ovl_cnt_r : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ovl_cnt_r <= '0;
    end else if (cmd.close_fin) begin
      ovl_cnt_r <= '0;
    end else if (add_keep) begin
      ovl_cnt_r <= ovl_cnt_r + OVL_CW'(1);
    end
  end

  // overlap store
  logic [STORE_W-1:0] store_mem [MAX_OVERLAPS];
  logic [STORE_W-1:0] store_q;
  logic [OVL_AW-1:0]  scan_idx_r;
  logic               rd_vld_r;

  always_ff @(posedge clk) begin
    if (add_keep) begin
      store_mem[ovl_cnt_r[OVL_AW-1:0]] <= {beg_r, end_r};
    end
    store_q <= store_mem[scan_idx_r];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_vld_r <= 1'b0;
    end else begin
      rd_vld_r <= cmd.scan_issue;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      scan_idx_r <= '0;
    end else if (cmd.scan_issue) begin
      scan_idx_r <= scan_idx_r + OVL_AW'(1);
    end
  end

  // selection scan: smallest key above the last one taken, with its multiplicity
  logic              best_vld_r, have_prev_r;
  logic [KEY_W-1:0]  best_key_r, prev_key_r;
  logic [OVL_CW-1:0] best_cnt_r, evt_cnt_r;
  logic              bv_c;
  logic [KEY_W-1:0]  bk_c;
  logic [OVL_CW-1:0] bc_c;
  logic [KEY_W-1:0]  keys [2];

  always_comb begin
    keys[0] = {store_q[STORE_W-1:POS_W], 1'b0};
    keys[1] = {store_q[POS_W-1:0] - POS_W'(1), 1'b1};
    bv_c = best_vld_r;
    bk_c = best_key_r;
    bc_c = best_cnt_r;
    for (int k = 0; k < 2; k++) begin
      if (!have_prev_r || (keys[k] > prev_key_r)) begin
        if (!bv_c || (keys[k] < bk_c)) begin
          bv_c = 1'b1;
          bk_c = keys[k];
          bc_c = OVL_CW'(1);
        end else if (keys[k] == bk_c) begin
          bc_c = bc_c + OVL_CW'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.scan_init) begin
      best_vld_r <= 1'b0;
      best_key_r <= '0;
      best_cnt_r <= '0;
    end else if (rd_vld_r) begin
      best_vld_r <= bv_c;
      best_key_r <= bk_c;
      best_cnt_r <= bc_c;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      have_prev_r <= 1'b0;
    end else if (cmd.cand_take) begin
      have_prev_r <= 1'b1;
      prev_key_r  <= best_key_r;
      evt_cnt_r   <= best_cnt_r;
    end else if (cmd.evt_end) begin
      evt_cnt_r <= evt_cnt_r - OVL_CW'(1);
    end
  end

  // position to bin division
  logic             div_busy;
  logic [POS_W-1:0] div_quo;
  logic [BW_W-1:0]  div_rem;

  bcih_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (cmd.cand_take),
    .dividend (best_key_r[KEY_W-1:1]),
    .divisor  (bw_r),
    .busy     (div_busy),
    .quo      (div_quo),
    .rem      (div_rem)
  );

  // event setup: bin range and depth for one endpoint
  logic              first_r, clip_r;
  logic [POS_W-1:0]  q_prev_r, qs;
  logic [SPAN_W-1:0] span_r;
  logic [KEY_W-1:0]  ceil_q, qs1, stop0;
  logic              over, vclip, bin_any;
  logic [BIN_CW-1:0] stop_c, stop_r;
  logic [BIN_AW-1:0] last_c, maxj_r, bin_idx_r;
  logic [DEP_AW-1:0] val_c, val_r, maxcov_r, cov_q, cov_new;

  assign qs      = first_r ? div_quo : q_prev_r;
  assign ceil_q  = {1'b0, div_quo} + KEY_W'(div_rem != '0);
  assign qs1     = {1'b0, qs} + KEY_W'(1);
  assign stop0   = (ceil_q < qs1) ? qs1 : ceil_q;
  assign over    = stop0 > KEY_W'(MAX_BINS);
  assign stop_c  = over ? BIN_CW'(MAX_BINS) : stop0[BIN_CW-1:0];
  assign last_c  = BIN_AW'(stop_c - BIN_CW'(1));
  assign vclip   = span_r > SPAN_W'(MAX_DEPTH - 1);
  assign val_c   = vclip ? DEP_AW'(MAX_DEPTH - 1) : span_r[DEP_AW-1:0];
  assign bin_any = {1'b0, qs} < KEY_W'(stop_c);
  assign cov_new = (cov_q > val_r) ? cov_q : val_r;

  // histogram signals
  logic [CNT_W-1:0]   hist_q;
  logic [HIST_AW-1:0] hist_ra, hwa_r, hc_r;
  logic               hist_sat;
  logic [DEP_AW-1:0]  md_r, mtop_r;
  logic [CNT_W-1:0]   mval_r;
  logic [DEP_AW-1:0]  set_top_r [NUM_SETS];

  assign hist_sat = hist_q == '1;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      first_r  <= 1'b1;
      span_r   <= '0;
      maxj_r   <= '0;
      maxcov_r <= '0;
      clip_r   <= 1'b0;
    end else begin
      if (cmd.evt_setup) begin
        val_r  <= val_c;
        stop_r <= stop_c;
        if (last_c > maxj_r) begin
          maxj_r <= last_c;
        end
        if (over || vclip) begin
          clip_r <= 1'b1;
        end
        span_r <= prev_key_r[0] ? span_r - SPAN_W'(1) : span_r + SPAN_W'(1);
      end
      if (cmd.evt_end) begin
        q_prev_r <= div_quo;
        first_r  <= 1'b0;
      end
      if (cmd.bin_wr && (cov_new > maxcov_r)) begin
        maxcov_r <= cov_new;
      end
      if (cmd.hist_wr && hist_sat) begin
        clip_r <= 1'b1;
      end
    end
  end

  // shared bin index: clear pass, sweep and histogram pass
  always_ff @(posedge clk) begin
    if (cmd.in_load || cmd.hist_init) begin
      bin_idx_r <= '0;
    end else if (cmd.evt_setup) begin
      bin_idx_r <= qs[BIN_AW-1:0];
    end else if (cmd.cclr_step || cmd.bin_wr || cmd.hist_wr) begin
      bin_idx_r <= bin_idx_r + BIN_AW'(1);
    end
  end

  // bin coverage memory
  logic [DEP_AW-1:0] cov_mem [MAX_BINS];

  always_ff @(posedge clk) begin
    if (cmd.cclr_step) begin
      cov_mem[bin_idx_r] <= '0;
    end else if (cmd.bin_wr) begin
      cov_mem[bin_idx_r] <= cov_new;
    end
    cov_q <= cov_mem[bin_idx_r];
  end

  // depth histogram memory
  logic [CNT_W-1:0] hist_mem [NUM_SETS * MAX_DEPTH];

  always_comb begin
    priority if (cmd.qcnt_rd) begin
      hist_ra = {set_r, dbin_r};
    end else if (cmd.mode_rd) begin
      hist_ra = {set_r, md_r};
    end else begin
      hist_ra = {set_r, cov_q};
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.hclr_step) begin
      hist_mem[hc_r] <= '0;
    end else if (cmd.hist_wr && !hist_sat) begin
      hist_mem[hwa_r] <= hist_q + CNT_W'(1);
    end
    hist_q <= hist_mem[hist_ra];
  end

  always_ff @(posedge clk) begin
    if (cmd.hist_rd_cnt) begin
      hwa_r <= hist_ra;
    end
  end

  // clearing pass counter after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hc_r <= '0;
    end else if (cmd.hclr_step) begin
      hc_r <= hc_r + HIST_AW'(1);
    end
  end

  // per-set top depth
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int s = 0; s < NUM_SETS; s++) begin
        set_top_r[s] <= '0;
      end
    end else if (cmd.close_fin && (maxcov_r > set_top_r[set_r])) begin
      set_top_r[set_r] <= maxcov_r;
    end
  end

  // mode scan
  always_ff @(posedge clk) begin
    if (cmd.mode_init) begin
      md_r   <= DEP_AW'(1);
      mtop_r <= set_top_r[set_r];
      mval_r <= '0;
    end else if (cmd.mode_cmp) begin
      md_r <= md_r + DEP_AW'(1);
      if (hist_q > mval_r) begin
        mval_r <= hist_q;
      end
    end
  end

  // result registers
  logic [STS_W-1:0]   res_status_r;
  logic [CNT_W-1:0]   res_count_r;
  logic [DEPTH_W-1:0] res_mode_r, res_peak_r;

  always_ff @(posedge clk) begin
    if (cmd.in_load) begin
      res_status_r <= STS_OK;
      res_count_r  <= '0;
      res_mode_r   <= '0;
      res_peak_r   <= '0;
    end else begin
      if (cmd.add_do && !add_drop && store_full) begin
        res_status_r <= STS_FULL;
      end
      if (cmd.qcnt_take) begin
        res_count_r <= hist_q;
      end
      if (cmd.mode_cmp && (hist_q > mval_r)) begin
        res_mode_r <= md_r;
      end
      if (cmd.close_fin) begin
        res_status_r <= clip_r ? STS_CLIP : STS_OK;
        res_peak_r   <= maxcov_r;
      end
    end
  end

  // output register
  logic [STS_W-1:0]   out_status_r;
  logic [CNT_W-1:0]   out_count_r;
  logic [DEPTH_W-1:0] out_mode_r, out_peak_r;

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      out_status_r <= res_status_r;
      out_count_r  <= res_count_r;
      out_mode_r   <= res_mode_r;
      out_peak_r   <= res_peak_r;
    end
  end

  assign out_status     = out_status_r;
  assign out_bin_count  = out_count_r;
  assign out_mode_depth = out_mode_r;
  assign out_read_peak  = out_peak_r;

  // status to the controller
  assign sts.hclr_last   = hc_r == '1;
  assign sts.cclr_last   = bin_idx_r == BIN_AW'(MAX_BINS - 1);
  assign sts.sweep_empty = n_eff == '0;
  assign sts.scan_last   = OVL_CW'(scan_idx_r) == (n_eff - OVL_CW'(1));
  assign sts.cand_found  = best_vld_r;
  assign sts.div_busy    = div_busy;
  assign sts.bin_any     = bin_any;
  assign sts.bin_last    = (BIN_CW'(bin_idx_r) + BIN_CW'(1)) == stop_r;
  assign sts.evt_more    = evt_cnt_r > OVL_CW'(1);
  assign sts.hist_last   = bin_idx_r == maxj_r;
  assign sts.mode_none   = set_top_r[set_r] == '0;
  assign sts.mode_last   = md_r == mtop_r;

endmodule

`default_nettype wire

@@ src/bcih_ctrl.sv @@
`default_nettype none

module bcih_ctrl (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic [bcih_pkg::CMD_W-1:0] in_command,
  output logic                       in_ready,
  output logic                       out_valid,
  input  logic                       out_ready,
  input  bcih_pkg::dp_sts_t          sts,
  output bcih_pkg::ctl_cmd_t         cmd
);
  import bcih_pkg::*;

  typedef enum logic [4:0] {
    ST_HCLR, ST_IDLE, ST_ADD, ST_CCLR, ST_SCAN, ST_SDRAIN, ST_SDEC, ST_DWAIT,
    ST_EVT, ST_BRD, ST_BWR, ST_EEND, ST_HRD, ST_HRD2, ST_HWR, ST_CFIN,
    ST_QRD, ST_QWT, ST_MINIT, ST_MRD, ST_MCMP, ST_OUT
  } state_t;

  state_t state_r, state_nxt;
  logic   out_valid_r, out_valid_nxt;

  // next state and datapath commands
  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    unique case (state_r)
      ST_HCLR: begin
        cmd.hclr_step = 1'b1;
        if (sts.hclr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_valid) begin
          cmd.in_load = 1'b1;
          unique case (cmd_code_t'(in_command))
            CMD_ADD:   state_nxt = ST_ADD;
            CMD_CLOSE: state_nxt = ST_CCLR;
            CMD_COUNT: state_nxt = ST_QRD;
            CMD_MODE:  state_nxt = ST_MINIT;
            default:   state_nxt = ST_IDLE;
          endcase
        end
      end
      ST_ADD: begin
        cmd.add_do = 1'b1;
        state_nxt  = ST_OUT;
      end
      ST_CCLR: begin
        cmd.cclr_step = 1'b1;
        if (sts.cclr_last) begin
          if (sts.sweep_empty) begin
            cmd.hist_init = 1'b1;
            state_nxt     = ST_HRD;
          end else begin
            cmd.scan_init = 1'b1;
            state_nxt     = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        cmd.scan_issue = 1'b1;
        if (sts.scan_last) state_nxt = ST_SDRAIN;
      end
      ST_SDRAIN: state_nxt = ST_SDEC;
      ST_SDEC: begin
        if (sts.cand_found) begin
          cmd.cand_take = 1'b1;
          state_nxt     = ST_DWAIT;
        end else begin
          cmd.hist_init = 1'b1;
          state_nxt     = ST_HRD;
        end
      end
      ST_DWAIT: begin
        if (!sts.div_busy) state_nxt = ST_EVT;
      end
      ST_EVT: begin
        cmd.evt_setup = 1'b1;
        state_nxt     = sts.bin_any ? ST_BRD : ST_EEND;
      end
      ST_BRD: state_nxt = ST_BWR;
      ST_BWR: begin
        cmd.bin_wr = 1'b1;
        state_nxt  = sts.bin_last ? ST_EEND : ST_BRD;
      end
      ST_EEND: begin
        cmd.evt_end = 1'b1;
        if (sts.evt_more) begin
          state_nxt = ST_EVT;
        end else begin
          cmd.scan_init = 1'b1;
          state_nxt     = ST_SCAN;
        end
      end
      ST_HRD: state_nxt = ST_HRD2;
      ST_HRD2: begin
        cmd.hist_rd_cnt = 1'b1;
        state_nxt       = ST_HWR;
      end
      ST_HWR: begin
        cmd.hist_wr = 1'b1;
        state_nxt   = sts.hist_last ? ST_CFIN : ST_HRD;
      end
      ST_CFIN: begin
        cmd.close_fin = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_QRD: begin
        cmd.qcnt_rd = 1'b1;
        state_nxt   = ST_QWT;
      end
      ST_QWT: begin
        cmd.qcnt_take = 1'b1;
        state_nxt     = ST_OUT;
      end
      ST_MINIT: begin
        cmd.mode_init = 1'b1;
        state_nxt     = sts.mode_none ? ST_OUT : ST_MRD;
      end
      ST_MRD: begin
        cmd.mode_rd = 1'b1;
        state_nxt   = ST_MCMP;
      end
      ST_MCMP: begin
        cmd.mode_cmp = 1'b1;
        state_nxt    = sts.mode_last ? ST_OUT : ST_MRD;
      end
      ST_OUT: begin
        if (!out_valid_r || out_ready) begin
          cmd.out_load = 1'b1;
          state_nxt    = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  // output beat valid
  always_comb begin
    out_valid_nxt = out_valid_r && !out_ready;
    if (cmd.out_load) out_valid_nxt = 1'b1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_HCLR;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_ready  = state_r == ST_IDLE;
  assign out_valid = out_valid_r;

endmodule

`default_nettype wire

@@ src/binned_interval_coverage_histogram_top.sv @@
`default_nettype none

// channel   dir  handshake            payload
// in_*      in   in_valid/in_ready    command, begin/end pos, self match, lengths, set, depth
// out_*     out  out_valid/out_ready  status, bin count, mode depth, read peak
// cfg_*     in   cfg_wr_en            cfg_index, cfg_data
//
// after reset a clearing pass zeroes all 16384 histogram entries; no beat is taken then.
// add: filter and store the overlap; count query: read the entry of set and depth bin;
// mode query: a read and a compare per depth up to the top depth of the set. close: clear
// all 4096 bins, then per distinct endpoint one pass over the n stored overlaps, a divide,
// a read and a write per bin swept, and a read and a write per bin in the histogram pass;
// the single-port bin and histogram memories and the selection scan over the store set the pace.
// one beat is in work at a time; a finished result waits in the output register.

module binned_interval_coverage_histogram_top (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_wr_en,
  input  logic [bcih_pkg::CFG_AW-1:0]  cfg_index,
  input  logic [bcih_pkg::POS_W-1:0]   cfg_data,
  input  logic                         in_valid,
  output logic                         in_ready,
  input  logic [bcih_pkg::CMD_W-1:0]   in_command,
  input  logic [bcih_pkg::POS_W-1:0]   in_begin_pos,
  input  logic [bcih_pkg::POS_W-1:0]   in_end_pos,
  input  logic                         in_self_match,
  input  logic [bcih_pkg::POS_W-1:0]   in_partner_len,
  input  logic [bcih_pkg::POS_W-1:0]   in_read_len,
  input  logic [bcih_pkg::SET_W-1:0]   in_set_id,
  input  logic [bcih_pkg::DEPTH_W-1:0] in_depth_bin,
  output logic                         out_valid,
  input  logic                         out_ready,
  output logic [bcih_pkg::STS_W-1:0]   out_status,
  output logic [bcih_pkg::CNT_W-1:0]   out_bin_count,
  output logic [bcih_pkg::DEPTH_W-1:0] out_mode_depth,
  output logic [bcih_pkg::DEPTH_W-1:0] out_read_peak
);
  import bcih_pkg::*;

  ctl_cmd_t cmd;
  dp_sts_t  sts;

  bcih_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_ready   (in_ready),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .sts        (sts),
    .cmd        (cmd)
  );

  bcih_datapath u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_begin_pos   (in_begin_pos),
    .in_end_pos     (in_end_pos),
    .in_self_match  (in_self_match),
    .in_partner_len (in_partner_len),
    .in_read_len    (in_read_len),
    .in_set_id      (in_set_id),
    .in_depth_bin   (in_depth_bin),
    .cmd            (cmd),
    .sts            (sts),
    .out_status     (out_status),
    .out_bin_count  (out_bin_count),
    .out_mode_depth (out_mode_depth),
    .out_read_peak  (out_read_peak)
  );

endmodule

`default_nettype wire

@@ src/bcih_checker.sv @@
`default_nettype none

module bcih_checker (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  input  logic                         in_ready,
  input  logic                         out_valid,
  input  logic                         out_ready,
  input  logic [bcih_pkg::STS_W-1:0]   out_status,
  input  logic [bcih_pkg::CNT_W-1:0]   out_bin_count,
  input  logic [bcih_pkg::DEPTH_W-1:0] out_mode_depth,
  input  logic [bcih_pkg::DEPTH_W-1:0] out_read_peak
);
  import bcih_pkg::*;

  // a stalled result beat holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_status) &&
    $stable(out_bin_count) && $stable(out_mode_depth) && $stable(out_read_peak))
    else $error("result beat changed while stalled");

  // reset leaves no result pending
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_valid && !in_ready)
    else $error("beat pending after reset");

  // one beat in work at a time
  a_one_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("second beat taken while busy");

  // an overlap refused by a full store carries no other result
  a_full_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STS_FULL) |->
    (out_bin_count == '0) && (out_mode_depth == '0) && (out_read_peak == '0))
    else $error("store-full result carries data");

  // status codes stay within the defined set
  a_sts_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_status == STS_OK) || (out_status == STS_FULL) ||
    (out_status == STS_CLIP))
    else $error("undefined status code");

endmodule

bind binned_interval_coverage_histogram_top bcih_checker u_chk (.*);

`default_nettype wire
